@@ rtl/pcint_pkg.sv @@
// Shared constants, register codes and types for the PID conditional-integration core.
package pcint_pkg;

   localparam int SumWidth    = 32;
   localparam int DriveWidth  = 48;
   localparam int SampleWidth = 16;
   localparam int GainWidth   = 16;
   localparam int LimitWidth  = 8;
   localparam int FracBits    = 8;
   localparam int ErrWidth    = SampleWidth + 1;
   localparam int DiffWidth   = ErrWidth + 1;
   localparam int PropWidth   = GainWidth + ErrWidth;
   localparam int IntegWidth  = GainWidth + SumWidth;
   localparam int DerivWidth  = GainWidth + DiffWidth;
   localparam int AccWidth    = IntegWidth + 2;
   localparam int CmpWidth    = ((AccWidth > DriveWidth) ? AccWidth : DriveWidth) + 1;
   localparam int AddrWidth   = 5;
   localparam int DataWidth   = 32;

   localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
   localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};
   localparam logic signed [DriveWidth-1:0] DriveMax = {1'b0, {(DriveWidth-1){1'b1}}};
   localparam logic signed [DriveWidth-1:0] DriveMin = {1'b1, {(DriveWidth-1){1'b0}}};

   localparam logic signed [LimitWidth-1:0] LowLimitReset  = {1'b1, {(LimitWidth-1){1'b0}}};
   localparam logic signed [LimitWidth-1:0] HighLimitReset = {1'b0, {(LimitWidth-1){1'b1}}};

   typedef enum logic [2:0] {
      RegPropGain    = 3'd0,
      RegIntegGain   = 3'd1,
      RegDerivGain   = 3'd2,
      RegTargetValue = 3'd3,
      RegLowLimit    = 3'd4,
      RegHighLimit   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [GainWidth-1:0]   prop_gain;
      logic signed [GainWidth-1:0]   integ_gain;
      logic signed [GainWidth-1:0]   deriv_gain;
      logic signed [SampleWidth-1:0] target_value;
      logic signed [LimitWidth-1:0]  low_limit;
      logic signed [LimitWidth-1:0]  high_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [ErrWidth-1:0] last_error;
      logic signed [SumWidth-1:0] error_sum;
      logic                       was_saturated;
   } loop_state_type;

endpackage

@@ rtl/pcint_req_if.sv @@
// Request channel: one measured sample per control tick.
interface pcint_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [pcint_pkg::SampleWidth-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

@@ rtl/pcint_rsp_if.sv @@
// Response channel: drive value and over-limit flag.
interface pcint_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [pcint_pkg::DriveWidth-1:0] drive;
   logic                                    over_limit;

   modport source (output valid, output drive, output over_limit, input ready);
   modport sink (input valid, input drive, input over_limit, output ready);
endinterface

@@ rtl/pid_conditional_integration_core.sv @@
// PID controller with conditional-integration anti-windup, top level.
// A request is captured in the input register, then one arithmetic pass carries
// it into the response register.
// Throughput: one request per cycle while response back-pressure does not stall it;
// the loop state (last error, error sum, saturation flag) updates in the same pass
// that fills the response register.
// Reset (synchronous, active high) clears the loop state and restores register defaults.
module pid_conditional_integration_core (
   input  logic                            clock,
   input  logic                            reset,
   pcint_req_if.sink                       req_chan,
   pcint_rsp_if.source                     rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pcint_pkg::AddrWidth-1:0] paddr,
   input  logic [pcint_pkg::DataWidth-1:0] pwdata,
   output logic [pcint_pkg::DataWidth-1:0] prdata,
   output logic                            pready
);

   pcint_pkg::cfg_type                       cfg;
   pcint_pkg::loop_state_type                state_ff;
   pcint_pkg::loop_state_type                state_in;
   pcint_pkg::loop_state_type                state_next;
   logic                                     in_valid_ff;
   logic signed [pcint_pkg::SampleWidth-1:0] sample_ff;
   logic                                     out_valid_ff;
   logic signed [pcint_pkg::DriveWidth-1:0]  drive_ff;
   logic                                     over_ff;
   logic signed [pcint_pkg::DriveWidth-1:0]  drive_calc;
   logic                                     over_calc;
   logic                                     advance;
   logic                                     take;

   pcint_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcint_calc u_calc (
      .cfg        (cfg),
      .state      (state_ff),
      .sample     (sample_ff),
      .state_next (state_next),
      .drive      (drive_calc),
      .over_limit (over_calc)
   );

   // the response register frees up when empty or when its response is taken
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   assign state_in = (in_valid_ff && advance) ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= req_chan.sample;
      end
      if (advance && in_valid_ff) begin
         drive_ff <= drive_calc;
         over_ff  <= over_calc;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.drive      = drive_ff;
   assign rsp_chan.over_limit = over_ff;

endmodule

@@ rtl/pcint_csr.sv @@
// APB-style register file holding gains, setpoint and limits.
module pcint_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pcint_pkg::AddrWidth-1:0]     paddr,
   input  logic [pcint_pkg::DataWidth-1:0]     pwdata,
   output logic [pcint_pkg::DataWidth-1:0]     prdata,
   output logic                                pready,
   output pcint_pkg::cfg_type                  cfg
);

   pcint_pkg::cfg_type       cfg_ff;
   pcint_pkg::cfg_type       cfg_in;
   pcint_pkg::reg_index_type index;
   logic                     write_en;

   assign pready   = 1'b1;
   assign index    = pcint_pkg::reg_index_type'(paddr[pcint_pkg::AddrWidth-1:2]);
   assign write_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            pcint_pkg::RegPropGain:    cfg_in.prop_gain    = pwdata[pcint_pkg::GainWidth-1:0];
            pcint_pkg::RegIntegGain:   cfg_in.integ_gain   = pwdata[pcint_pkg::GainWidth-1:0];
            pcint_pkg::RegDerivGain:   cfg_in.deriv_gain   = pwdata[pcint_pkg::GainWidth-1:0];
            pcint_pkg::RegTargetValue: cfg_in.target_value = pwdata[pcint_pkg::SampleWidth-1:0];
            pcint_pkg::RegLowLimit:    cfg_in.low_limit    = pwdata[pcint_pkg::LimitWidth-1:0];
            pcint_pkg::RegHighLimit:   cfg_in.high_limit   = pwdata[pcint_pkg::LimitWidth-1:0];
            default: begin
               // drop writes beyond the register list
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= '0;
         cfg_ff.integ_gain   <= '0;
         cfg_ff.deriv_gain   <= '0;
         cfg_ff.target_value <= '0;
         cfg_ff.low_limit    <= pcint_pkg::LowLimitReset;
         cfg_ff.high_limit   <= pcint_pkg::HighLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         pcint_pkg::RegPropGain:
            prdata = pcint_pkg::DataWidth'(unsigned'(cfg_ff.prop_gain));
         pcint_pkg::RegIntegGain:
            prdata = pcint_pkg::DataWidth'(unsigned'(cfg_ff.integ_gain));
         pcint_pkg::RegDerivGain:
            prdata = pcint_pkg::DataWidth'(unsigned'(cfg_ff.deriv_gain));
         pcint_pkg::RegTargetValue:
            prdata = pcint_pkg::DataWidth'(unsigned'(cfg_ff.target_value));
         pcint_pkg::RegLowLimit:
            prdata = pcint_pkg::DataWidth'(unsigned'(cfg_ff.low_limit));
         pcint_pkg::RegHighLimit:
            prdata = pcint_pkg::DataWidth'(unsigned'(cfg_ff.high_limit));
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/pcint_calc.sv @@
// One control-tick pass: error, gated integral, derivative, drive and limit check.
module pcint_calc (
   input  pcint_pkg::cfg_type                       cfg,
   input  pcint_pkg::loop_state_type                state,
   input  logic signed [pcint_pkg::SampleWidth-1:0] sample,
   output pcint_pkg::loop_state_type                state_next,
   output logic signed [pcint_pkg::DriveWidth-1:0]  drive,
   output logic                                     over_limit
);

   logic signed [pcint_pkg::ErrWidth-1:0]   err;
   logic signed [pcint_pkg::SumWidth:0]     sum_wide;
   logic signed [pcint_pkg::SumWidth-1:0]   sum_sat;
   logic signed [pcint_pkg::SumWidth-1:0]   sum_next;
   logic signed [pcint_pkg::DiffWidth-1:0]  diff;
   logic signed [pcint_pkg::PropWidth-1:0]  p_term;
   logic signed [pcint_pkg::IntegWidth-1:0] i_term;
   logic signed [pcint_pkg::DerivWidth-1:0] d_term;
   logic signed [pcint_pkg::AccWidth-1:0]   acc;
   logic signed [pcint_pkg::CmpWidth-1:0]   acc_ext;
   logic signed [pcint_pkg::DriveWidth-1:0] low_scaled;
   logic signed [pcint_pkg::DriveWidth-1:0] high_scaled;

   always_comb begin
      err = pcint_pkg::ErrWidth'(cfg.target_value) - pcint_pkg::ErrWidth'(sample);

      // integrate only when the previous drive stayed inside the limits
      sum_wide = (pcint_pkg::SumWidth+1)'(state.error_sum) + (pcint_pkg::SumWidth+1)'(err);
      if (sum_wide[pcint_pkg::SumWidth] != sum_wide[pcint_pkg::SumWidth-1]) begin
         sum_sat = sum_wide[pcint_pkg::SumWidth] ? pcint_pkg::SumMin : pcint_pkg::SumMax;
      end else begin
         sum_sat = sum_wide[pcint_pkg::SumWidth-1:0];
      end
      sum_next = state.was_saturated ? state.error_sum : sum_sat;

      diff = pcint_pkg::DiffWidth'(err) - pcint_pkg::DiffWidth'(state.last_error);

      p_term = pcint_pkg::PropWidth'(cfg.prop_gain) * pcint_pkg::PropWidth'(err);
      i_term = pcint_pkg::IntegWidth'(cfg.integ_gain) * pcint_pkg::IntegWidth'(sum_next);
      d_term = pcint_pkg::DerivWidth'(cfg.deriv_gain) * pcint_pkg::DerivWidth'(diff);

      acc = pcint_pkg::AccWidth'(p_term) + pcint_pkg::AccWidth'(i_term)
          + pcint_pkg::AccWidth'(d_term);
      acc_ext = pcint_pkg::CmpWidth'(acc);

      priority if (acc_ext > pcint_pkg::CmpWidth'(pcint_pkg::DriveMax)) begin
         drive = pcint_pkg::DriveMax;
      end else if (acc_ext < pcint_pkg::CmpWidth'(pcint_pkg::DriveMin)) begin
         drive = pcint_pkg::DriveMin;
      end else begin
         drive = acc_ext[pcint_pkg::DriveWidth-1:0];
      end

      // limits are integers: scale by the fraction bits
      low_scaled  = $signed({{(pcint_pkg::DriveWidth-pcint_pkg::LimitWidth-pcint_pkg::FracBits)
                              {cfg.low_limit[pcint_pkg::LimitWidth-1]}},
                             cfg.low_limit, {pcint_pkg::FracBits{1'b0}}});
      high_scaled = $signed({{(pcint_pkg::DriveWidth-pcint_pkg::LimitWidth-pcint_pkg::FracBits)
                              {cfg.high_limit[pcint_pkg::LimitWidth-1]}},
                             cfg.high_limit, {pcint_pkg::FracBits{1'b0}}});
      over_limit = (drive < low_scaled) || (drive > high_scaled);

      state_next.last_error    = err;
      state_next.error_sum     = sum_next;
      state_next.was_saturated = over_limit;
   end

endmodule

@@ test/tb_pid_conditional_integration_core.sv @@
// Testbench for the PID conditional-integration core: predicted drive values checked per request.
`timescale 1ns / 1ps

module tb_pid_conditional_integration_core;

   localparam int StallLimit    = 2000;
   localparam int HoldOffCycles = 60;
   localparam int DrainCycles   = 4;
   localparam int PhaseItems    = 116;
   localparam int RandomPhases  = 8;
   localparam int QuietRun      = 20;
   localparam logic [2:0] RegUnused0 = 3'd6;
   localparam logic [2:0] RegUnused1 = 3'd7;

   typedef struct packed {
      logic signed [pcint_pkg::DriveWidth-1:0] drive;
      logic                                    over_limit;
   } drive_result_type;

   // Mirror of the controller: registers, loop state and the drives still owed.
   class drive_scoreboard;
      pcint_pkg::cfg_type        regs;
      pcint_pkg::loop_state_type loop;
      drive_result_type          expected_drives[$];
      int                        n_checked;

      function new();
         regs = '0;
         regs.low_limit = pcint_pkg::LowLimitReset;
         regs.high_limit = pcint_pkg::HighLimitReset;
         loop = '0;
         n_checked = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [pcint_pkg::DataWidth-1:0] word);
         case (index)
            pcint_pkg::RegPropGain:
               regs.prop_gain = word[pcint_pkg::GainWidth-1:0];
            pcint_pkg::RegIntegGain:
               regs.integ_gain = word[pcint_pkg::GainWidth-1:0];
            pcint_pkg::RegDerivGain:
               regs.deriv_gain = word[pcint_pkg::GainWidth-1:0];
            pcint_pkg::RegTargetValue:
               regs.target_value = word[pcint_pkg::SampleWidth-1:0];
            pcint_pkg::RegLowLimit:
               regs.low_limit = word[pcint_pkg::LimitWidth-1:0];
            pcint_pkg::RegHighLimit:
               regs.high_limit = word[pcint_pkg::LimitWidth-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [pcint_pkg::SampleWidth-1:0] sample);
         longint err;
         longint diff;
         longint acc;
         longint sum;
         drive_result_type r;
         err = longint'($signed(regs.target_value)) - longint'(sample);
         // anti-windup: hold the sum while the previous drive was out of limits
         if (!loop.was_saturated) begin
            sum = longint'($signed(loop.error_sum)) + err;
            if (sum > longint'(pcint_pkg::SumMax)) sum = longint'(pcint_pkg::SumMax);
            else if (sum < longint'(pcint_pkg::SumMin)) sum = longint'(pcint_pkg::SumMin);
            loop.error_sum = sum[pcint_pkg::SumWidth-1:0];
         end
         diff = err - longint'($signed(loop.last_error));
         acc = longint'($signed(regs.prop_gain)) * err
             + longint'($signed(regs.integ_gain)) * longint'($signed(loop.error_sum))
             + longint'($signed(regs.deriv_gain)) * diff;
         if (acc > longint'(pcint_pkg::DriveMax)) acc = longint'(pcint_pkg::DriveMax);
         else if (acc < longint'(pcint_pkg::DriveMin)) acc = longint'(pcint_pkg::DriveMin);
         r.drive = acc[pcint_pkg::DriveWidth-1:0];
         r.over_limit =
            (acc < (longint'($signed(regs.low_limit)) <<< pcint_pkg::FracBits)) ||
            (acc > (longint'($signed(regs.high_limit)) <<< pcint_pkg::FracBits));
         loop.was_saturated = r.over_limit;
         loop.last_error = err[pcint_pkg::ErrWidth-1:0];
         expected_drives.push_back(r);
      endfunction

      function bit check_drive(logic signed [pcint_pkg::DriveWidth-1:0] drive,
                               logic over_limit, output string detail);
         drive_result_type want;
         n_checked++;
         detail = "";
         if (expected_drives.size() == 0) begin
            detail = $sformatf("result %0d: drive %0d with nothing expected", n_checked, drive);
            return 1'b0;
         end
         want = expected_drives.pop_front();
         if (drive !== want.drive)
            detail = {detail, $sformatf(" drive %0d, expected %0d", drive, want.drive)};
         if (over_limit !== want.over_limit)
            detail = {detail, $sformatf(" over_limit %b, expected %b", over_limit,
                                        want.over_limit)};
         if (detail == "") return 1'b1;
         detail = $sformatf("result %0d:%s", n_checked, detail);
         return 1'b0;
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [pcint_pkg::AddrWidth-1:0] paddr;
   logic [pcint_pkg::DataWidth-1:0] pwdata;
   logic [pcint_pkg::DataWidth-1:0] prdata;
   logic                            pready;

   pcint_req_if req_chan();
   pcint_rsp_if rsp_chan();

   drive_scoreboard sb = new();
   int    mismatches = 0;
   int    idle_cycles = 0;
   int    send_quiet = 0;
   int    recv_quiet = 0;
   bit    hold_off_pending = 1'b0;
   string detail;

   pid_conditional_integration_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 20) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Caller stands at a rising edge; the task returns the bus to idle after the access phase.
   task automatic write_register(input logic [2:0] index, input int value);
      logic [pcint_pkg::DataWidth-1:0] word;
      word = $urandom();
      case (index)
         pcint_pkg::RegLowLimit, pcint_pkg::RegHighLimit:
            word[pcint_pkg::LimitWidth-1:0] = value[pcint_pkg::LimitWidth-1:0];
         pcint_pkg::RegPropGain, pcint_pkg::RegIntegGain, pcint_pkg::RegDerivGain,
         pcint_pkg::RegTargetValue:
            word[pcint_pkg::GainWidth-1:0] = value[pcint_pkg::GainWidth-1:0];
         default: ;
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(index, word);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure(input int prop, input int integ, input int deriv,
                            input int target, input int low, input int high);
      wait_drained();
      write_register(pcint_pkg::RegPropGain, prop);
      write_register(pcint_pkg::RegIntegGain, integ);
      write_register(pcint_pkg::RegDerivGain, deriv);
      write_register(pcint_pkg::RegTargetValue, target);
      write_register(pcint_pkg::RegLowLimit, low);
      write_register(pcint_pkg::RegHighLimit, high);
   endtask

   task automatic send_sample(input logic signed [pcint_pkg::SampleWidth-1:0] sample);
      int gap;
      if (send_quiet > 0) begin
         send_quiet--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         send_quiet = QuietRun;
         gap = 0;
      end else gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= sample;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_sample(sample);
   endtask

   // Response side: random back-pressure, quiet runs and one long hold-off.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            gap = HoldOffCycles;
         end else if (recv_quiet > 0) begin
            recv_quiet--;
            gap = 0;
         end else if ($urandom_range(0, 15) == 0) begin
            recv_quiet = QuietRun;
            gap = 0;
         end else gap = $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (!sb.check_drive(rsp_chan.drive, rsp_chan.over_limit, detail))
               report_mismatch(detail);
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= StallLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int p;
      int k;
      int v;
      int low;
      int high;
      int extremes[5];
      logic signed [pcint_pkg::SampleWidth-1:0] s;
      extremes = '{-32768, 32767, 0, 1, -1};
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.sample <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: all gains zero
      send_sample(16'sh0000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      configure(32767, -32768, 32767, -32768, -128, 127);
      // writes past the last register must leave the map untouched
      write_register(RegUnused0, 0);
      write_register(RegUnused1, 0);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sd0);

      // crossed limits
      configure(-32768, 32767, -32768, 32767, 127, -128);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sd0);
      send_sample(16'sd100);
      send_sample(-16'sd100);

      // unit gains with tight limits: integration switches on and off
      configure(256, 256, 256, 0, -1, 1);
      send_sample(16'sd0);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd2);
      send_sample(16'sd0);
      send_sample(-16'sd2);

      for (p = 0; p < RandomPhases; p++) begin
         if (p == 3) begin
            configure(extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)],
                      extremes[$urandom_range(0, 4)], int'($urandom_range(0, 65535)) - 32768,
                      -128, 127);
         end else begin
            if (p == 5) begin
               low = $urandom_range(1, 127);
               high = int'($urandom_range(0, 128)) - 128;
            end else begin
               low = -int'($urandom_range(0, 128));
               high = $urandom_range(0, 127);
            end
            configure(int'($urandom_range(0, 1024)) - 512, int'($urandom_range(0, 1024)) - 512,
                      int'($urandom_range(0, 1024)) - 512,
                      int'($urandom_range(0, 65535)) - 32768, low, high);
         end
         if (p == 0) hold_off_pending = 1'b1;
         for (k = 0; k < PhaseItems; k++) begin
            if ($urandom_range(0, 9) < 8) begin
               v = int'(sb.regs.target_value) + int'($urandom_range(0, 128)) - 64;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               s = v[pcint_pkg::SampleWidth-1:0];
            end else begin
               s = 16'($urandom());
            end
            send_sample(s);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
